[sv/ppmfd_pkg.sv]
`default_nettype none

package ppmfd_pkg;

   localparam int CHANNEL_COUNT_DEFAULT = 8;
   localparam int EDGE_WIDTH = 32;
   localparam int SLOT_WIDTH = 4;
   localparam int CHAN_WIDTH = 16;
   localparam int RATE_WIDTH = 10;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int VIEW_COUNT = 5;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLAMP_LOW = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CLAMP_HIGH = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_GAP = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ARM_THRESHOLD = 2'd3;

   localparam logic [CHAN_WIDTH-1:0] CLAMP_LOW_RESET = 16'd1000;
   localparam logic [CHAN_WIDTH-1:0] CLAMP_HIGH_RESET = 16'd2000;
   localparam logic [CHAN_WIDTH-1:0] SYNC_GAP_RESET = 16'd3000;
   localparam logic [CHAN_WIDTH-1:0] ARM_THRESHOLD_RESET = 16'd1950;

   localparam logic [CHAN_WIDTH-1:0] CONNECT_LOW = 16'd900;
   localparam logic [CHAN_WIDTH-1:0] CONNECT_HIGH = 16'd2100;

   // Positions of the channels that the stick outputs read, channel n at n-1.
   localparam int VIEW_ROLL = 0;
   localparam int VIEW_PITCH = 1;
   localparam int VIEW_THROTTLE = 2;
   localparam int VIEW_YAW = 3;
   localparam int VIEW_ARM = 4;

   localparam logic signed [CHAN_WIDTH:0] RATE_CENTER = 17'sd1000;
   localparam logic signed [CHAN_WIDTH:0] RATE_SAT_DELTA = 17'sd3345;
   localparam int RATE_SHIFT = 21;
   localparam int PROD_WIDTH = RATE_SHIFT + RATE_WIDTH;
   localparam logic [PROD_WIDTH-1:0] RATE_RECIP = 31'd377496;
   localparam logic signed [RATE_WIDTH:0] RATE_OFFSET = 11'sd90;
   localparam logic signed [RATE_WIDTH-1:0] RATE_MAX = 10'sd511;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] clamp_low;
      logic [CHAN_WIDTH-1:0] clamp_high;
      logic [CHAN_WIDTH-1:0] sync_gap;
      logic [CHAN_WIDTH-1:0] arm_threshold;
   } cfg_type;

   typedef struct packed {
      logic [SLOT_WIDTH-1:0] slot;
      logic [CHAN_WIDTH-1:0] width;
      logic sync;
      logic [VIEW_COUNT-1:0][CHAN_WIDTH-1:0] chan;
   } dec_type;

   // Maps a width as (w - 1000) * 180 / 1000 - 90 with truncation toward zero,
   // saturated to the signed 10-bit range. The divide by 50 is a multiply by
   // a reciprocal that is exact for magnitudes below the saturation point.
   function automatic logic signed [RATE_WIDTH-1:0] map_rate(input logic [CHAN_WIDTH-1:0] w);
      logic signed [CHAN_WIDTH:0] delta;
      logic [11:0] mag;
      logic [PROD_WIDTH-1:0] prod;
      logic [RATE_WIDTH-1:0] quot;
      logic signed [RATE_WIDTH:0] value;
      delta = $signed({1'b0, w}) - RATE_CENTER;
      mag = delta[CHAN_WIDTH] ? 12'(-delta) : 12'(delta);
      prod = PROD_WIDTH'(mag) * RATE_RECIP;
      quot = prod[PROD_WIDTH-1:RATE_SHIFT];
      value = delta[CHAN_WIDTH] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
      value = value - RATE_OFFSET;
      if (delta >= RATE_SAT_DELTA) begin
         return RATE_MAX;
      end
      return RATE_WIDTH'(value);
   endfunction

endpackage

`default_nettype wire

[sv/ppmfd_decode.sv]
`default_nettype none

module ppmfd_decode #(
   parameter int CHANNEL_COUNT = ppmfd_pkg::CHANNEL_COUNT_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire ppmfd_pkg::cfg_type cfg,
   input  wire logic in_valid,
   output logic in_ready,
   input  wire logic [ppmfd_pkg::EDGE_WIDTH-1:0] in_edge_time,
   output logic out_valid,
   input  wire logic out_ready,
   output ppmfd_pkg::dec_type out_dec
);

   localparam int CH_INDEX_WIDTH = $clog2(CHANNEL_COUNT);
   localparam logic [ppmfd_pkg::SLOT_WIDTH-1:0] LAST_CHAN_SLOT =
      ppmfd_pkg::SLOT_WIDTH'(CHANNEL_COUNT);
   localparam logic [ppmfd_pkg::SLOT_WIDTH-1:0] SYNC_SLOT =
      ppmfd_pkg::SLOT_WIDTH'(CHANNEL_COUNT + 1);
   localparam logic [ppmfd_pkg::SLOT_WIDTH-1:0] SLOT_HUNT = '0;
   localparam logic [ppmfd_pkg::SLOT_WIDTH-1:0] SLOT_FIRST = 4'd1;

   logic [ppmfd_pkg::EDGE_WIDTH-1:0] last_edge_ff;
   logic [ppmfd_pkg::SLOT_WIDTH-1:0] slot_ff;
   logic [ppmfd_pkg::SLOT_WIDTH-1:0] slot_in;
   logic [ppmfd_pkg::CHAN_WIDTH-1:0] chan_ff [CHANNEL_COUNT];
   logic out_valid_ff;
   ppmfd_pkg::dec_type dec_ff;
   ppmfd_pkg::dec_type dec_in;

   logic advance;
   logic [ppmfd_pkg::EDGE_WIDTH-1:0] interval;
   logic hunting;
   logic chan_slot;
   logic [ppmfd_pkg::CHAN_WIDTH-1:0] width;
   logic [CH_INDEX_WIDTH-1:0] chan_index;

   assign in_ready = !out_valid_ff || out_ready;
   assign advance = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_dec = dec_ff;

   assign interval = in_edge_time - last_edge_ff;
   assign hunting = (slot_ff == SLOT_HUNT) || (slot_ff > SYNC_SLOT);
   assign chan_slot = !hunting && (slot_ff <= LAST_CHAN_SLOT);
   assign chan_index = CH_INDEX_WIDTH'(slot_ff - SLOT_FIRST);

   always_comb begin
      if (chan_slot) begin
         if (interval < {16'd0, cfg.clamp_low}) begin
            width = cfg.clamp_low;
         end else if (interval > {16'd0, cfg.clamp_high}) begin
            width = cfg.clamp_high;
         end else begin
            width = interval[ppmfd_pkg::CHAN_WIDTH-1:0];
         end
      end else if (!hunting) begin
         width = (interval[ppmfd_pkg::EDGE_WIDTH-1:ppmfd_pkg::CHAN_WIDTH] != '0) ?
            '1 : interval[ppmfd_pkg::CHAN_WIDTH-1:0];
      end else begin
         width = '0;
      end
   end

   always_comb begin
      dec_in.slot = hunting ? SLOT_HUNT : slot_ff;
      dec_in.width = width;
      dec_in.sync = !hunting && (interval > {16'd0, cfg.sync_gap});
      for (int n = 0; n < ppmfd_pkg::VIEW_COUNT; n++) begin
         dec_in.chan[n] = (chan_slot && slot_ff == ppmfd_pkg::SLOT_WIDTH'(n + 1)) ?
            width : chan_ff[n];
      end
      if (hunting) begin
         slot_in = SLOT_FIRST;
      end else if (chan_slot) begin
         slot_in = slot_ff + SLOT_FIRST;
      end else begin
         slot_in = SLOT_HUNT;
      end
      if (dec_in.sync) begin
         slot_in = SLOT_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_edge_ff <= '0;
         slot_ff <= SLOT_HUNT;
         out_valid_ff <= 1'b0;
         for (int n = 0; n < CHANNEL_COUNT; n++) begin
            chan_ff[n] <= '0;
         end
      end else begin
         if (advance) begin
            last_edge_ff <= in_edge_time;
            slot_ff <= slot_in;
            if (chan_slot) begin
               chan_ff[chan_index] <= width;
            end
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dec_ff <= dec_in;
      end
   end

endmodule

`default_nettype wire

[sv/ppmfd_map.sv]
`default_nettype none

module ppmfd_map (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic [ppmfd_pkg::CHAN_WIDTH-1:0] arm_threshold,
   input  wire logic in_valid,
   output logic in_ready,
   input  wire ppmfd_pkg::dec_type in_dec,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [ppmfd_pkg::SLOT_WIDTH-1:0] rsp_updated_slot,
   output logic [ppmfd_pkg::CHAN_WIDTH-1:0] rsp_slot_width,
   output logic rsp_sync_seen,
   output logic [ppmfd_pkg::CHAN_WIDTH-1:0] rsp_throttle,
   output logic signed [ppmfd_pkg::RATE_WIDTH-1:0] rsp_roll_rate,
   output logic signed [ppmfd_pkg::RATE_WIDTH-1:0] rsp_pitch_rate,
   output logic signed [ppmfd_pkg::RATE_WIDTH-1:0] rsp_yaw_rate,
   output logic rsp_armed,
   output logic rsp_connected
);

   logic valid_ff;
   logic advance;
   logic [ppmfd_pkg::CHAN_WIDTH-1:0] throttle_in;

   assign in_ready = !valid_ff || rsp_ready;
   assign advance = in_valid && in_ready;
   assign rsp_valid = valid_ff;
   assign throttle_in = in_dec.chan[ppmfd_pkg::VIEW_THROTTLE];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_updated_slot <= in_dec.slot;
         rsp_slot_width <= in_dec.width;
         rsp_sync_seen <= in_dec.sync;
         rsp_throttle <= throttle_in;
         rsp_roll_rate <= ppmfd_pkg::map_rate(in_dec.chan[ppmfd_pkg::VIEW_ROLL]);
         rsp_pitch_rate <= ppmfd_pkg::map_rate(in_dec.chan[ppmfd_pkg::VIEW_PITCH]);
         rsp_yaw_rate <= ppmfd_pkg::map_rate(in_dec.chan[ppmfd_pkg::VIEW_YAW]);
         rsp_armed <= in_dec.chan[ppmfd_pkg::VIEW_ARM] > arm_threshold;
         rsp_connected <= (throttle_in >= ppmfd_pkg::CONNECT_LOW) &&
            (throttle_in <= ppmfd_pkg::CONNECT_HIGH);
      end
   end

endmodule

`default_nettype wire

[sv/ppm_frame_decoder.sv]
// PPM frame decoder. Each transfer on the req_ channel carries the microsecond
// timestamp of one rising edge of the PPM stream; each edge produces exactly one
// transfer on the rsp_ channel, in order, with the decoded slot, its width, the
// sync flag and the stick values (throttle, roll, pitch, yaw, armed, connected)
// as they stand after that edge.
// The block is a three-register pipeline: an input register, a decode stage that
// holds the last edge time, the slot counter and the channel widths, and a
// result register that maps the sticks. One edge is accepted every cycle while
// rsp_ready stays high.
// When rsp_ready is low the result register holds, the stages behind it fill,
// and req_ready falls only once all three hold an item.
// Reset clears the pipeline, the slot counter, the last edge time and the
// channel widths, and loads the default limits. The first edge after reset only
// takes the reference time and reports slot 0. The csr_ port writes the limits;
// the user must use it only while idle, and the block does not enforce this.
`default_nettype none

module ppm_frame_decoder #(
   parameter int CHANNEL_COUNT = ppmfd_pkg::CHANNEL_COUNT_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [ppmfd_pkg::EDGE_WIDTH-1:0] req_edge_time,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic [ppmfd_pkg::SLOT_WIDTH-1:0] rsp_updated_slot,
   output logic [ppmfd_pkg::CHAN_WIDTH-1:0] rsp_slot_width,
   output logic rsp_sync_seen,
   output logic [ppmfd_pkg::CHAN_WIDTH-1:0] rsp_throttle,
   output logic signed [ppmfd_pkg::RATE_WIDTH-1:0] rsp_roll_rate,
   output logic signed [ppmfd_pkg::RATE_WIDTH-1:0] rsp_pitch_rate,
   output logic signed [ppmfd_pkg::RATE_WIDTH-1:0] rsp_yaw_rate,
   output logic rsp_armed,
   output logic rsp_connected,
   input  wire logic csr_wr_en,
   input  wire logic [ppmfd_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [ppmfd_pkg::CHAN_WIDTH-1:0] csr_wr_data
);

   ppmfd_pkg::cfg_type cfg_ff;
   logic in_valid_ff;
   logic [ppmfd_pkg::EDGE_WIDTH-1:0] in_edge_ff;
   logic dec_in_ready;
   logic dec_valid;
   logic map_in_ready;
   ppmfd_pkg::dec_type dec;

   assign req_ready = !in_valid_ff || dec_in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.clamp_low <= ppmfd_pkg::CLAMP_LOW_RESET;
         cfg_ff.clamp_high <= ppmfd_pkg::CLAMP_HIGH_RESET;
         cfg_ff.sync_gap <= ppmfd_pkg::SYNC_GAP_RESET;
         cfg_ff.arm_threshold <= ppmfd_pkg::ARM_THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ppmfd_pkg::CSR_CLAMP_LOW: cfg_ff.clamp_low <= csr_wr_data;
            ppmfd_pkg::CSR_CLAMP_HIGH: cfg_ff.clamp_high <= csr_wr_data;
            ppmfd_pkg::CSR_SYNC_GAP: cfg_ff.sync_gap <= csr_wr_data;
            ppmfd_pkg::CSR_ARM_THRESHOLD: cfg_ff.arm_threshold <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_edge_ff <= req_edge_time;
      end
   end

   ppmfd_decode #(
      .CHANNEL_COUNT(CHANNEL_COUNT)
   ) u_decode (
      .clock(clock),
      .reset(reset),
      .cfg(cfg_ff),
      .in_valid(in_valid_ff),
      .in_ready(dec_in_ready),
      .in_edge_time(in_edge_ff),
      .out_valid(dec_valid),
      .out_ready(map_in_ready),
      .out_dec(dec)
   );

   ppmfd_map u_map (
      .clock(clock),
      .reset(reset),
      .arm_threshold(cfg_ff.arm_threshold),
      .in_valid(dec_valid),
      .in_ready(map_in_ready),
      .in_dec(dec),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_updated_slot(rsp_updated_slot),
      .rsp_slot_width(rsp_slot_width),
      .rsp_sync_seen(rsp_sync_seen),
      .rsp_throttle(rsp_throttle),
      .rsp_roll_rate(rsp_roll_rate),
      .rsp_pitch_rate(rsp_pitch_rate),
      .rsp_yaw_rate(rsp_yaw_rate),
      .rsp_armed(rsp_armed),
      .rsp_connected(rsp_connected)
   );

endmodule

`default_nettype wire
